// ----- src/hpp_pkg.sv -----
// hpp_pkg: shared types, widths and constants of the heater pi pwm controller
// no dependencies; used by the interfaces, the serial units and the top level

package hpp_pkg;

  // field and register widths
  localparam int unsigned TEMP_W   = 13;
  localparam int unsigned ERR_W    = TEMP_W + 1;
  localparam int unsigned KP_W     = 16;
  localparam int unsigned KI_W     = 24;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W   = 15;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // register reset values
  localparam logic [TEMP_W-1:0]   SETPOINT_RST = TEMP_W'(0);
  localparam logic [KP_W-1:0]     KP_RST       = KP_W'(852);
  localparam logic [KI_W-1:0]     KI_RST       = KI_W'(30454);
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(0);

  // shift-add multiplier: signed multiplicand, unsigned multiplier
  localparam int unsigned MUL_A_W   = 32;
  localparam int unsigned MUL_B_W   = 24;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  // fixed-point scaling
  localparam int unsigned P_SHIFT   = 4;
  localparam int unsigned I_SHIFT   = 20;
  localparam int unsigned PTERM_W   = KP_W + ERR_W + 1 - P_SHIFT;
  localparam int unsigned ITERM_W   = MUL_P_W - I_SHIFT;
  localparam int unsigned RAW_W     = ITERM_W + 1;
  localparam int unsigned DUTY_FULL = 25600;

  // compare value: (duty * period) >> 8, then divided by 100
  localparam int unsigned CMP_PRE_SHIFT = 8;
  localparam int unsigned CMP_DIVISOR   = 100;
  localparam int unsigned DIV_N_W       = 23;
  localparam int unsigned DIV_R_W       = 7;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_N_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 2'd0,
    REG_KP       = 2'd1,
    REG_KI       = 2'd2,
    REG_PERIOD   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_CLAMP,
    ST_MUL_C,
    ST_DIV,
    ST_PUSH
  } ctrl_state_e;

endpackage

// ----- src/hpp_if.sv -----
// hpp_if: valid/ready channels for the measurement word and the result word
// depends on hpp_pkg for the field widths

interface hpp_meas_if;
  logic                         valid;
  logic                         ready;
  logic [hpp_pkg::TEMP_W-1:0]   measured_temp;

  modport source (output valid, output measured_temp, input ready);
  modport sink   (input valid, input measured_temp, output ready);
endinterface

interface hpp_res_if;
  logic                         valid;
  logic                         ready;
  logic [hpp_pkg::DUTY_W-1:0]   duty;
  logic [hpp_pkg::CMP_W-1:0]    pwm_cmp;
  logic                         clamped_high;
  logic                         clamped_low;

  modport source (output valid, output duty, output pwm_cmp,
                  output clamped_high, output clamped_low, input ready);
  modport sink   (input valid, input duty, input pwm_cmp,
                  input clamped_high, input clamped_low, output ready);
endinterface

// ----- src/heater_pi_pwm_controller_unit.sv -----
// heater_pi_pwm_controller_unit: pi heater controller with clamped duty and pwm compare value
// depends on hpp_pkg, hpp_if, hpp_ser_mul and hpp_div_const

// One measured temperature word in gives one result word out. The block forms
// error = setpoint - measured, adds it to a 32-bit integral that saturates, and builds
// duty = (kp*error >>> 4) + (ki*integral >>> 20) in 1/256 percent, clamped to 0..25600
// with flags for either clamp. The compare value is floor(duty*period/25600). All three
// products go through one shared shift-add multiplier that retires one multiplier bit
// per cycle (24 steps each), and the compare value then goes through a bit-serial divide
// by one hundred (23 steps) before the result is registered in the output register.
// Only one word is in flight; a new word is taken as soon as the previous result sits
// in the output register, even if it is not yet taken.
// Configuration writes land at once and must only happen while the block is idle.

module heater_pi_pwm_controller_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hpp_pkg::CFG_W-1:0]        cfg_data_i,
  hpp_meas_if.sink                         meas_i,
  hpp_res_if.source                        res_o
);

  // configuration registers
  logic [hpp_pkg::TEMP_W-1:0]     setpoint_q;
  logic [hpp_pkg::KP_W-1:0]       kp_q;
  logic [hpp_pkg::KI_W-1:0]       ki_q;
  logic [hpp_pkg::PERIOD_W-1:0]   period_q;

  // controller state and intermediate terms
  hpp_pkg::ctrl_state_e           state_q, state_d;
  logic signed [hpp_pkg::INTEG_W-1:0] integ_q;
  logic signed [hpp_pkg::PTERM_W-1:0] pterm_q;
  logic signed [hpp_pkg::RAW_W-1:0]   raw_q;
  logic [hpp_pkg::DUTY_W-1:0]     duty_q, duty_d;
  logic                           hi_q, hi_d, lo_q, lo_d;
  logic [hpp_pkg::CMP_W-1:0]      cmp_q;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [hpp_pkg::DUTY_W-1:0]     out_duty_q;
  logic [hpp_pkg::CMP_W-1:0]      out_cmp_q;
  logic                           out_hi_q, out_lo_q;

  // handshake and datapath controls
  logic                           in_ready, accept, push;
  logic                           mul_start, mul_done, div_start, div_done;
  logic signed [hpp_pkg::MUL_A_W-1:0] mul_a;
  logic [hpp_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [hpp_pkg::MUL_P_W-1:0] prod;
  logic [hpp_pkg::CMP_W-1:0]      quo;

  logic signed [hpp_pkg::ERR_W-1:0]   err;
  logic signed [hpp_pkg::INTEG_W:0]   integ_sum;
  logic signed [hpp_pkg::INTEG_W-1:0] integ_sat;
  logic signed [hpp_pkg::ITERM_W-1:0] iterm;
  logic signed [hpp_pkg::RAW_W-1:0]   raw_sum;

  assign accept = meas_i.valid && in_ready;

  // error of the incoming word, one bit wider than the temperatures
  assign err = $signed({1'b0, setpoint_q}) - $signed({1'b0, meas_i.measured_temp});

  // saturating integral update
  assign integ_sum = {integ_q[hpp_pkg::INTEG_W-1], integ_q}
                   + {{(hpp_pkg::INTEG_W + 1 - hpp_pkg::ERR_W){err[hpp_pkg::ERR_W-1]}}, err};
  always_comb begin
    if (integ_sum[hpp_pkg::INTEG_W] != integ_sum[hpp_pkg::INTEG_W-1]) begin
      integ_sat = integ_sum[hpp_pkg::INTEG_W]
                ? {1'b1, {(hpp_pkg::INTEG_W - 1){1'b0}}}
                : {1'b0, {(hpp_pkg::INTEG_W - 1){1'b1}}};
    end else begin
      integ_sat = integ_sum[hpp_pkg::INTEG_W-1:0];
    end
  end

  // integral term: floor of the product over 2^20 is the upper product bits
  assign iterm   = prod[hpp_pkg::MUL_P_W-1:hpp_pkg::I_SHIFT];
  assign raw_sum = {{(hpp_pkg::RAW_W - hpp_pkg::PTERM_W){pterm_q[hpp_pkg::PTERM_W-1]}}, pterm_q}
                 + {iterm[hpp_pkg::ITERM_W-1], iterm};

  // clamp to 0..100 percent, signed compare so a negative raw duty is never high
  always_comb begin
    hi_d   = 1'b0;
    lo_d   = 1'b0;
    duty_d = raw_q[hpp_pkg::DUTY_W-1:0];
    if (raw_q > $signed(hpp_pkg::RAW_W'(hpp_pkg::DUTY_FULL))) begin
      hi_d   = 1'b1;
      duty_d = hpp_pkg::DUTY_W'(hpp_pkg::DUTY_FULL);
    end else if (raw_q[hpp_pkg::RAW_W-1]) begin
      lo_d   = 1'b1;
      duty_d = '0;
    end
  end

  assign push = (state_q == hpp_pkg::ST_PUSH) && (!out_valid_q || res_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hpp_pkg::ST_IDLE:  if (accept)   state_d = hpp_pkg::ST_MUL_P;
      hpp_pkg::ST_MUL_P: if (mul_done) state_d = hpp_pkg::ST_MUL_I;
      hpp_pkg::ST_MUL_I: if (mul_done) state_d = hpp_pkg::ST_CLAMP;
      hpp_pkg::ST_CLAMP: state_d = hpp_pkg::ST_MUL_C;
      hpp_pkg::ST_MUL_C: if (mul_done) state_d = hpp_pkg::ST_DIV;
      hpp_pkg::ST_DIV:   if (div_done) state_d = hpp_pkg::ST_PUSH;
      hpp_pkg::ST_PUSH:  if (push)     state_d = hpp_pkg::ST_IDLE;
      default:           state_d = hpp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: input ready, multiplier operands and unit starts
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      hpp_pkg::ST_IDLE: begin
        // proportional product: error times kp
        in_ready  = 1'b1;
        mul_start = accept;
        mul_a     = {{(hpp_pkg::MUL_A_W - hpp_pkg::ERR_W){err[hpp_pkg::ERR_W-1]}}, err};
        mul_b     = {{(hpp_pkg::MUL_B_W - hpp_pkg::KP_W){1'b0}}, kp_q};
      end
      hpp_pkg::ST_MUL_P: begin
        // integral product: integral times ki
        mul_start = mul_done;
        mul_a     = integ_q;
        mul_b     = ki_q;
      end
      hpp_pkg::ST_CLAMP: begin
        // compare product: clamped duty times period
        mul_start = 1'b1;
        mul_a     = {{(hpp_pkg::MUL_A_W - hpp_pkg::DUTY_W){1'b0}}, duty_d};
        mul_b     = {{(hpp_pkg::MUL_B_W - hpp_pkg::PERIOD_W){1'b0}}, period_q};
      end
      hpp_pkg::ST_MUL_C: div_start = mul_done;
      default: begin
      end
    endcase
  end

  assign out_valid_d = push ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hpp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      setpoint_q  <= hpp_pkg::SETPOINT_RST;
      kp_q        <= hpp_pkg::KP_RST;
      ki_q        <= hpp_pkg::KI_RST;
      period_q    <= hpp_pkg::PERIOD_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        integ_q <= integ_sat;
      end
      if (cfg_we_i) begin
        case (hpp_pkg::cfg_reg_e'(cfg_idx_i))
          hpp_pkg::REG_SETPOINT: setpoint_q <= cfg_data_i[hpp_pkg::TEMP_W-1:0];
          hpp_pkg::REG_KP:       kp_q       <= cfg_data_i[hpp_pkg::KP_W-1:0];
          hpp_pkg::REG_KI:       ki_q       <= cfg_data_i[hpp_pkg::KI_W-1:0];
          hpp_pkg::REG_PERIOD:   period_q   <= cfg_data_i[hpp_pkg::PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == hpp_pkg::ST_MUL_P && mul_done) begin
      // proportional term: floor of the product over 16
      pterm_q <= prod[hpp_pkg::PTERM_W + hpp_pkg::P_SHIFT - 1:hpp_pkg::P_SHIFT];
    end
    if (state_q == hpp_pkg::ST_MUL_I && mul_done) begin
      raw_q <= raw_sum;
    end
    if (state_q == hpp_pkg::ST_CLAMP) begin
      duty_q <= duty_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
    if (state_q == hpp_pkg::ST_DIV && div_done) begin
      cmp_q <= quo;
    end
    if (push) begin
      out_duty_q <= duty_q;
      out_cmp_q  <= cmp_q;
      out_hi_q   <= hi_q;
      out_lo_q   <= lo_q;
    end
  end

  hpp_ser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // duty*period over 25600 is (product >> 8) over 100
  hpp_div_const u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[hpp_pkg::DIV_N_W + hpp_pkg::CMP_PRE_SHIFT - 1:hpp_pkg::CMP_PRE_SHIFT]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign meas_i.ready        = in_ready;
  assign res_o.valid         = out_valid_q;
  assign res_o.duty          = out_duty_q;
  assign res_o.pwm_cmp       = out_cmp_q;
  assign res_o.clamped_high  = out_hi_q;
  assign res_o.clamped_low   = out_lo_q;

endmodule

// ----- src/hpp_ser_mul.sv -----
// hpp_ser_mul: radix-2 shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; depends on hpp_pkg

module hpp_ser_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [hpp_pkg::MUL_A_W-1:0]  a_i,
  input  logic [hpp_pkg::MUL_B_W-1:0]         b_i,
  output logic                                done_o,
  output logic signed [hpp_pkg::MUL_P_W-1:0]  prod_o
);

  logic signed [hpp_pkg::MUL_A_W-1:0]   a_q;
  logic signed [hpp_pkg::MUL_A_W:0]     hi_q, hi_d, sum;
  logic [hpp_pkg::MUL_B_W-1:0]          lo_q, lo_d;
  logic [hpp_pkg::MUL_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                 run_q, run_d, done_q, done_d;
  logic                                 last;

  assign last = (cnt_q == hpp_pkg::MUL_CNT_W'(hpp_pkg::MUL_B_W - 1));

  // add the multiplicand when the current multiplier bit is set
  assign sum = hi_q + (lo_q[0] ? {a_q[hpp_pkg::MUL_A_W-1], a_q}
                               : {(hpp_pkg::MUL_A_W + 1){1'b0}});

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      hi_d  = '0;
      lo_d  = b_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      hi_d  = sum >>> 1;
      lo_d  = {sum[0], lo_q[hpp_pkg::MUL_B_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[hpp_pkg::MUL_A_W-1:0], lo_q};

endmodule

// ----- src/hpp_div_const.sv -----
// hpp_div_const: restoring divider by the constant hundred, one quotient bit per cycle
// depends on hpp_pkg

module hpp_div_const (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hpp_pkg::DIV_N_W-1:0]       num_i,
  output logic                              done_o,
  output logic [hpp_pkg::CMP_W-1:0]         quo_o
);

  logic [hpp_pkg::DIV_R_W-1:0]    rem_q, rem_d;
  logic [hpp_pkg::DIV_N_W-1:0]    quo_q, quo_d;
  logic [hpp_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           run_q, run_d, done_q, done_d;
  logic [hpp_pkg::DIV_R_W:0]      trial;
  logic                           fits;

  assign trial = {rem_q, quo_q[hpp_pkg::DIV_N_W-1]};
  assign fits  = (trial >= (hpp_pkg::DIV_R_W + 1)'(hpp_pkg::CMP_DIVISOR));

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      // remainder stays below the divisor, so the trial fits one extra bit
      rem_d = fits ? hpp_pkg::DIV_R_W'(trial - (hpp_pkg::DIV_R_W + 1)'(hpp_pkg::CMP_DIVISOR))
                   : trial[hpp_pkg::DIV_R_W-1:0];
      quo_d = {quo_q[hpp_pkg::DIV_N_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == hpp_pkg::DIV_CNT_W'(hpp_pkg::DIV_N_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // quotient never exceeds sixteen bits for in-range duty and period
  assign done_o = done_q;
  assign quo_o  = quo_q[hpp_pkg::CMP_W-1:0];

endmodule

// ----- verif/tb_heater_pi_pwm_controller_unit.sv -----
// tb_heater_pi_pwm_controller_unit: self-checking bench for the pi heater controller
// drives measurement words and register writes, predicts every result word and checks it
// depends on hpp_pkg, hpp_if and the heater_pi_pwm_controller_unit rtl

module tb_heater_pi_pwm_controller_unit;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 10;
  // longer than one word takes inside the block, with plenty of margin on top
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned CYCLE_LIMIT   = 2000000;

  // duty math runs in 64-bit signed, so keep these signed too
  localparam longint DUTY_MAX  = 25600;
  localparam longint INTEG_MAX = 2147483647;
  localparam longint INTEG_MIN = -longint'(2147483647) - 1;

  // one result word as the block presents it
  typedef struct packed {
    logic [hpp_pkg::DUTY_W-1:0] duty;
    logic [hpp_pkg::CMP_W-1:0]  pwm_cmp;
    logic                       clamped_high;
    logic                       clamped_low;
  } res_t;

  localparam res_t NO_RES = '0;

  typedef enum logic [0:0] {
    ROW_CFG,
    ROW_MEAS
  } row_kind_e;

  // directed row: either a register write or a measurement word, the latter with an
  // optional hand-typed expected result
  typedef struct packed {
    row_kind_e                  kind;
    hpp_pkg::cfg_reg_e          cfg_sel;
    logic [hpp_pkg::CFG_W-1:0]  cfg_data;
    logic [hpp_pkg::TEMP_W-1:0] meas;
    logic                       hand_typed;
    res_t                       want;
  } dir_row_t;

  typedef enum logic [2:0] {
    CM_TYPICAL,
    CM_RAW,
    CM_MAX,
    CM_TINY,
    CM_MODERATE
  } cfg_mode_e;

  typedef struct {
    int unsigned idle_pct;
    int unsigned stall_pct;
    cfg_mode_e   mode;
    int unsigned n_words;
    bit          squeeze;
  } phase_t;

  localparam int unsigned DIR_ROWS = 23;
  localparam int unsigned N_PHASES = 9;

  // the walk starts from reset values: setpoint 0, kp 852, ki 30454, period 0
  dir_row_t dir_tab [DIR_ROWS] = '{
    // error zero right after reset: everything zero
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd0,    1'b1, '{15'd0, 16'd0, 1'b0, 1'b0}},
    // largest negative error: duty below zero
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8191, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b1}},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd4096, 1'b0, NO_RES},
    // all-ones data, upper bits must be masked off
    '{ROW_CFG,  hpp_pkg::REG_SETPOINT, 24'hFFFFFF, 13'd0, 1'b0, NO_RES},
    '{ROW_CFG,  hpp_pkg::REG_PERIOD,   24'hFFFFFF, 13'd0, 1'b0, NO_RES},
    // largest positive error: clamp high, compare at full period
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd0,
      1'b1, '{15'd25600, 16'd65535, 1'b1, 1'b0}},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8191, 1'b0, NO_RES},
    // zero period with full duty: compare stays zero
    '{ROW_CFG,  hpp_pkg::REG_PERIOD,   24'h000000, 13'd0, 1'b0, NO_RES},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd0,    1'b1, '{15'd25600, 16'd0, 1'b1, 1'b0}},
    // integral path alone at the largest gain
    '{ROW_CFG,  hpp_pkg::REG_KP,       24'h000000, 13'd0, 1'b0, NO_RES},
    '{ROW_CFG,  hpp_pkg::REG_KI,       24'hFFFFFF, 13'd0, 1'b0, NO_RES},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8191, 1'b1, '{15'd25600, 16'd0, 1'b1, 1'b0}},
    // proportional path alone at the largest gain, period 25600 so compare equals duty
    '{ROW_CFG,  hpp_pkg::REG_KI,       24'h000000, 13'd0, 1'b0, NO_RES},
    '{ROW_CFG,  hpp_pkg::REG_KP,       24'hFFFFFF, 13'd0, 1'b0, NO_RES},
    '{ROW_CFG,  hpp_pkg::REG_PERIOD,   24'hFF6400, 13'd0, 1'b0, NO_RES},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8190, 1'b1, '{15'd4095, 16'd4095, 1'b0, 1'b0}},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8191, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b0}},
    // error of minus one: the shift floors to -4096
    '{ROW_CFG,  hpp_pkg::REG_SETPOINT, 24'h001FFE, 13'd0, 1'b0, NO_RES},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd8191, 1'b1, '{15'd0, 16'd0, 1'b0, 1'b1}},
    // raw duty exactly 100 percent: no clamp flag
    '{ROW_CFG,  hpp_pkg::REG_KP,       24'h001000, 13'd0, 1'b0, NO_RES},
    '{ROW_CFG,  hpp_pkg::REG_SETPOINT, 24'h000064, 13'd0, 1'b0, NO_RES},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd0,
      1'b1, '{15'd25600, 16'd25600, 1'b0, 1'b0}},
    '{ROW_MEAS, hpp_pkg::REG_SETPOINT, 24'h0, 13'd1,    1'b0, NO_RES}
  };

  // random phases: idle and stall mix, register setting, word count, long sink hold-off
  phase_t phase_tab [N_PHASES] = '{
    '{0,  0,  CM_TYPICAL,  200, 1'b0},
    '{88, 0,  CM_RAW,      200, 1'b0},
    '{0,  88, CM_MODERATE, 200, 1'b0},
    '{36, 36, CM_MAX,      180, 1'b0},
    '{0,  0,  CM_TINY,     150, 1'b0},
    '{0,  0,  CM_TYPICAL,  60,  1'b1},
    '{88, 0,  CM_MODERATE, 220, 1'b0},
    '{0,  88, CM_TYPICAL,  220, 1'b0},
    '{36, 36, CM_RAW,      200, 1'b0}
  };

  logic                          clk;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [hpp_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [hpp_pkg::CFG_W-1:0]     cfg_data;
  logic                          hold_go;

  hpp_meas_if meas_if ();
  hpp_res_if  res_if ();

  heater_pi_pwm_controller_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .meas_i     (meas_if),
    .res_o      (res_if)
  );

  // mirror of the register file and the integral the predictor works from
  logic [hpp_pkg::TEMP_W-1:0]          sp_reg      = hpp_pkg::SETPOINT_RST;
  logic [hpp_pkg::KP_W-1:0]            kp_reg      = hpp_pkg::KP_RST;
  logic [hpp_pkg::KI_W-1:0]            ki_reg      = hpp_pkg::KI_RST;
  logic [hpp_pkg::PERIOD_W-1:0]        period_reg  = hpp_pkg::PERIOD_RST;
  logic signed [hpp_pkg::INTEG_W-1:0]  pi_integral = '0;

  res_t        pending_duty_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  // expected result word for one measurement; advances the integral mirror
  function automatic res_t calc_duty_word(input logic [hpp_pkg::TEMP_W-1:0] meas);
    longint err;
    longint acc;
    longint pterm;
    longint iterm;
    longint raw;
    longint cmp_full;
    res_t   r;
    err = longint'(sp_reg) - longint'(meas);
    acc = longint'(pi_integral) + err;
    // integral saturates at the 32-bit signed limits
    if (acc > INTEG_MAX) begin
      acc = INTEG_MAX;
    end else if (acc < INTEG_MIN) begin
      acc = INTEG_MIN;
    end
    pi_integral = acc[hpp_pkg::INTEG_W-1:0];
    // arithmetic shifts floor toward minus infinity
    pterm = (longint'(kp_reg) * err) >>> hpp_pkg::P_SHIFT;
    iterm = (longint'(ki_reg) * longint'(pi_integral)) >>> hpp_pkg::I_SHIFT;
    raw = pterm + iterm;
    r.clamped_high = 1'b0;
    r.clamped_low  = 1'b0;
    if (raw > DUTY_MAX) begin
      r.duty = hpp_pkg::DUTY_W'(DUTY_MAX);
      r.clamped_high = 1'b1;
    end else if (raw < 0) begin
      r.duty = '0;
      r.clamped_low = 1'b1;
    end else begin
      r.duty = raw[hpp_pkg::DUTY_W-1:0];
    end
    cmp_full = (longint'(r.duty) * longint'(period_reg)) / DUTY_MAX;
    r.pwm_cmp = cmp_full[hpp_pkg::CMP_W-1:0];
    return r;
  endfunction

  // mostly words near the setpoint so the duty lands inside the range and the integral
  // wanders both ways; the rest spans the whole field and its two ends
  function automatic logic [hpp_pkg::TEMP_W-1:0] pick_meas();
    int v;
    int span;
    case ($urandom_range(9))
      0: v = int'($urandom_range(8191));
      1: v = ($urandom_range(1) != 0) ? 8191 : 0;
      default: begin
        span = ($urandom_range(3) == 0) ? 600 : 40;
        v = int'(sp_reg) + int'($urandom_range(2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
      end
    endcase
    return v[hpp_pkg::TEMP_W-1:0];
  endfunction

  // offer one measurement word, with a random gap in front, and log its expectation
  task automatic send_meas(input logic [hpp_pkg::TEMP_W-1:0] t, input logic hand_typed,
                           input res_t want);
    res_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      meas_if.valid <= 1'b0;
      meas_if.measured_temp <= hpp_pkg::TEMP_W'($urandom());
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    meas_if.valid <= 1'b1;
    meas_if.measured_temp <= t;
    @(posedge clk);
    while (!meas_if.ready) @(posedge clk);
    // word taken at this edge; predictor runs even for hand-typed rows to keep state
    pred = calc_duty_word(t);
    pending_duty_q.push_back(hand_typed ? want : pred);
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_results_done();
    meas_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_duty_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input hpp_pkg::cfg_reg_e sel,
                           input logic [hpp_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= hpp_pkg::CFG_W'($urandom());
    @(posedge clk);
    // bits above each register's width are dropped
    case (sel)
      hpp_pkg::REG_SETPOINT: sp_reg     = data[hpp_pkg::TEMP_W-1:0];
      hpp_pkg::REG_KP:       kp_reg     = data[hpp_pkg::KP_W-1:0];
      hpp_pkg::REG_KI:       ki_reg     = data[hpp_pkg::KI_W-1:0];
      hpp_pkg::REG_PERIOD:   period_reg = data[hpp_pkg::PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_phase_cfg(input cfg_mode_e mode);
    logic [hpp_pkg::CFG_W-1:0] d_sp;
    logic [hpp_pkg::CFG_W-1:0] d_kp;
    logic [hpp_pkg::CFG_W-1:0] d_ki;
    logic [hpp_pkg::CFG_W-1:0] d_per;
    case (mode)
      CM_TYPICAL: begin
        d_sp  = hpp_pkg::CFG_W'($urandom_range(8191));
        d_kp  = hpp_pkg::CFG_W'(hpp_pkg::KP_RST);
        d_ki  = hpp_pkg::CFG_W'(hpp_pkg::KI_RST);
        d_per = hpp_pkg::CFG_W'($urandom_range(65535));
      end
      CM_RAW: begin
        d_sp  = hpp_pkg::CFG_W'($urandom());
        d_kp  = hpp_pkg::CFG_W'($urandom());
        d_ki  = hpp_pkg::CFG_W'($urandom());
        d_per = hpp_pkg::CFG_W'($urandom());
      end
      CM_MAX: begin
        d_sp  = '1;
        d_kp  = '1;
        d_ki  = '1;
        d_per = '1;
      end
      CM_TINY: begin
        d_sp  = hpp_pkg::CFG_W'(8191);
        d_kp  = hpp_pkg::CFG_W'(1);
        d_ki  = hpp_pkg::CFG_W'(1);
        d_per = hpp_pkg::CFG_W'(1);
      end
      default: begin
        d_sp  = hpp_pkg::CFG_W'($urandom_range(8191));
        d_kp  = hpp_pkg::CFG_W'($urandom_range(4096));
        d_ki  = hpp_pkg::CFG_W'($urandom_range(1 << 20));
        d_per = hpp_pkg::CFG_W'($urandom_range(65535));
      end
    endcase
    write_reg(hpp_pkg::REG_SETPOINT, d_sp);
    write_reg(hpp_pkg::REG_KP, d_kp);
    write_reg(hpp_pkg::REG_KI, d_ki);
    write_reg(hpp_pkg::REG_PERIOD, d_per);
  endtask

  // sink side: random stalls, plus a long hold-off counted here when the stimulus asks
  initial begin : sink_side
    int unsigned hold_left;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_go) begin
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin : res_check
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_duty_q.size() == 0) begin
        report_mismatch("result word with nothing expected", res_if.duty, 0);
      end else begin
        want = pending_duty_q.pop_front();
        if (res_if.duty !== want.duty)
          report_mismatch("duty", res_if.duty, want.duty);
        if (res_if.pwm_cmp !== want.pwm_cmp)
          report_mismatch("pwm_cmp", res_if.pwm_cmp, want.pwm_cmp);
        if (res_if.clamped_high !== want.clamped_high)
          report_mismatch("clamped_high", res_if.clamped_high, want.clamped_high);
        if (res_if.clamped_low !== want.clamped_low)
          report_mismatch("clamped_low", res_if.clamped_low, want.clamped_low);
      end
    end
  end

  // hard stop if the block hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    clk      = 1'b0;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    hold_go  = 1'b0;
    meas_if.valid = 1'b0;
    meas_if.measured_temp = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed walk: register writes only once the block has drained
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_results_done();
        write_reg(dir_tab[i].cfg_sel, dir_tab[i].cfg_data);
      end else begin
        send_meas(dir_tab[i].meas, dir_tab[i].hand_typed, dir_tab[i].want);
      end
    end

    // random phases; integral saturation would take over a quarter million words of
    // full error, far past this run, so only the approach toward the limits is covered
    foreach (phase_tab[p]) begin
      wait_results_done();
      set_phase_cfg(phase_tab[p].mode);
      send_idle_pct  = phase_tab[p].idle_pct;
      recv_stall_pct = phase_tab[p].stall_pct;
      if (phase_tab[p].squeeze) begin
        // sink holds off while the source keeps offering, so the input stalls
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int unsigned n = 0; n < phase_tab[p].n_words; n++) begin
        send_meas(pick_meas(), 1'b0, NO_RES);
      end
    end

    wait_results_done();
    // any stray word in this window is flagged by the checker
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hpp_pkg.sv
src/hpp_if.sv
src/hpp_ser_mul.sv
src/hpp_div_const.sv
src/heater_pi_pwm_controller_unit.sv
verif/tb_heater_pi_pwm_controller_unit.sv
